// File: rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// amd_pkg
// Shared types, register indexes, constants and helper functions for the
// mic decimate / gate / agc / duck block.
// ----------------------------------------------------------------------------
package amd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIC_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AGC_TARGET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUCK_DEPTH = 3'd4;

	localparam int DIV_W = 48;
	localparam int DVS_W = 32;

	localparam logic [16:0] UNITY      = 17'd65536;
	localparam logic [19:0] AGC_MAX    = 20'd786432;
	localparam logic [15:0] GATE_REL   = 16'd65479;
	localparam logic [15:0] AGC_ATK    = 16'd39322;
	localparam logic [15:0] AGC_REL    = 16'd62259;
	localparam logic [14:0] AGC_SMOOTH = 15'd13107;
	localparam logic [9:0]  GATE_UP    = 10'd819;
	localparam logic [9:0]  GATE_DN    = 10'd27;
	localparam logic [10:0] DUCK_DN    = 11'd1311;
	localparam logic [10:0] DUCK_UP    = 11'd197;
	localparam logic [6:0]  DUCK_FULL  = 7'd100;
	// ceil(2^32 / 100), exact floor for the percent scale
	localparam logic [25:0] PCT_RECIP  = 26'd42949673;

	typedef struct packed {
		logic capture;
		logic acc;
		logic gain;
		logic genv;
		logic glvl;
		logic gmul;
		logic store;
		logic grp_clr;
		logic aenv;
		logic adiv;
		logic alvl;
		logic alvl2;
		logic dflr;
		logic rd;
		logic rdw;
		logic amul;
		logic duck;
		logic dmul;
		logic out_load;
		logic idx_inc;
		logic frame_clr;
	} amd_cmd_t;

	typedef struct packed {
		logic grp_close;
		logic gate_on;
		logic agc_on;
		logic duck_on;
		logic fend;
		logic fill_zero;
		logic div_done;
		logic idx_last;
		logic out_free;
	} amd_sts_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		if (v < -48'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// arithmetic right shift rounding toward zero
	function automatic logic signed [47:0] tz_shr(input logic signed [47:0] v, input int sh);
		logic signed [47:0] bias;
		bias = v < 0 ? ((48'sd1 <<< sh) - 48'sd1) : 48'sd0;
		return (v + bias) >>> sh;
	endfunction

endpackage

// File: rtl/amd_ram.sv
// ----------------------------------------------------------------------------
// amd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [$clog2(DEPTH < 2 ? 2 : DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [$clog2(DEPTH < 2 ? 2 : DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/amd_div.sv
// ----------------------------------------------------------------------------
// amd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [amd_pkg::DIV_W-1:0] dividend,
	input  logic [amd_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [amd_pkg::DIV_W-1:0] quotient
);
	import amd_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]    cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fit;

	assign trial = {rem_q, quotient[DIV_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			dvs_q    <= divisor;
			quotient <= dividend;
		end else if (cnt_q != '0) begin
			rem_q    <= fit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quotient <= {quotient[DIV_W-2:0], fit};
		end
	end
endmodule

// File: rtl/amd_ctrl.sv
// ----------------------------------------------------------------------------
// amd_ctrl
// Sequencer: steps one codec sample through decimation and gate, and at the
// frame mark runs the agc update, if enabled, and the frame playout loop.
// ----------------------------------------------------------------------------
module amd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  amd_pkg::amd_sts_t sts,
	output amd_pkg::amd_cmd_t cmd
);
	import amd_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_ACC    = 5'd1;
	localparam logic [4:0] ST_DIVA   = 5'd2;
	localparam logic [4:0] ST_GAIN   = 5'd3;
	localparam logic [4:0] ST_GENV   = 5'd4;
	localparam logic [4:0] ST_GLVL   = 5'd5;
	localparam logic [4:0] ST_GMUL   = 5'd6;
	localparam logic [4:0] ST_STORE  = 5'd7;
	localparam logic [4:0] ST_FEND   = 5'd8;
	localparam logic [4:0] ST_AENV   = 5'd9;
	localparam logic [4:0] ST_ASTART = 5'd10;
	localparam logic [4:0] ST_AWAIT  = 5'd11;
	localparam logic [4:0] ST_ALVL   = 5'd12;
	localparam logic [4:0] ST_ALVL2  = 5'd13;
	localparam logic [4:0] ST_DFLR   = 5'd14;
	localparam logic [4:0] ST_RD     = 5'd15;
	localparam logic [4:0] ST_RDW    = 5'd16;
	localparam logic [4:0] ST_AMUL   = 5'd17;
	localparam logic [4:0] ST_DUCK   = 5'd18;
	localparam logic [4:0] ST_DMUL   = 5'd19;
	localparam logic [4:0] ST_OUT    = 5'd20;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.grp_close ? ST_DIVA : ST_FEND;
			end
			ST_DIVA: begin
				if (sts.div_done) state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = sts.gate_on ? ST_GENV : ST_STORE;
			end
			ST_GENV: begin
				cmd.genv = 1'b1;
				state_d  = ST_GLVL;
			end
			ST_GLVL: begin
				cmd.glvl = 1'b1;
				state_d  = ST_GMUL;
			end
			ST_GMUL: begin
				cmd.gmul = 1'b1;
				state_d  = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ST_FEND;
			end
			ST_FEND: begin
				if (!sts.fend) begin
					state_d = ST_IDLE;
				end else begin
					cmd.grp_clr = 1'b1;
					if (sts.fill_zero) state_d = ST_IDLE;
					else if (sts.agc_on) state_d = ST_AENV;
					else state_d = ST_DFLR;
				end
			end
			ST_AENV: begin
				cmd.aenv = 1'b1;
				state_d  = ST_ASTART;
			end
			ST_ASTART: begin
				cmd.adiv = 1'b1;
				state_d  = ST_AWAIT;
			end
			ST_AWAIT: begin
				if (sts.div_done) state_d = ST_ALVL;
			end
			ST_ALVL: begin
				cmd.alvl = 1'b1;
				state_d  = ST_ALVL2;
			end
			ST_ALVL2: begin
				cmd.alvl2 = 1'b1;
				state_d   = ST_DFLR;
			end
			ST_DFLR: begin
				cmd.dflr = 1'b1;
				state_d  = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_RDW;
			end
			ST_RDW: begin
				cmd.rdw = 1'b1;
				if (sts.agc_on) state_d = ST_AMUL;
				else if (sts.duck_on) state_d = ST_DUCK;
				else state_d = ST_OUT;
			end
			ST_AMUL: begin
				cmd.amul = 1'b1;
				state_d  = sts.duck_on ? ST_DUCK : ST_OUT;
			end
			ST_DUCK: begin
				cmd.duck = 1'b1;
				state_d  = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.dmul = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.frame_clr = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/amd_dp.sv
// ----------------------------------------------------------------------------
// amd_dp
// Datapath: config registers, decimator, gate, frame store, agc, ducking
// and the output register.
// ----------------------------------------------------------------------------
module amd_dp #(
	parameter int FRAME_SAMPLES  = 64,
	parameter int MAX_DECIMATION = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  amd_pkg::amd_cmd_t             cmd,
	output amd_pkg::amd_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [amd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [amd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic signed [15:0]            in_sample,
	input  logic                          in_fend,
	input  logic                          in_far,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [15:0]                   out_sample,
	output logic                          out_last
);
	import amd_pkg::*;

	localparam int CNT_W   = $clog2(MAX_DECIMATION + 1);
	localparam int SUM_W   = 16 + $clog2(MAX_DECIMATION);
	localparam int DEC_MAX = MAX_DECIMATION > 15 ? 15 : MAX_DECIMATION;
	localparam int FILL_W  = $clog2(FRAME_SAMPLES + 1);
	localparam int AW      = $clog2(FRAME_SAMPLES < 2 ? 2 : FRAME_SAMPLES);
	localparam int GP_W    = SUM_W + 13;

	// configuration
	logic [3:0]  dec_cfg_q;
	logic [11:0] mic_gain_q;
	logic [14:0] gate_thr_q;
	logic [14:0] agc_target_q;
	logic [6:0]  duck_depth_q;

	// state
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic [31:0]             genv_q;
	logic [16:0]             glvl_q;
	logic [FILL_W-1:0]       fill_q;
	logic [15:0]             peak_q;
	logic [31:0]             aenv_q;
	logic [19:0]             alvl_q;
	logic [16:0]             duck_q;
	logic [16:0]             floor_q;
	logic signed [35:0]      dprod_q;
	logic [FILL_W-1:0]       idx_q;
	logic signed [15:0]      s_q;
	logic signed [15:0]      x_q;
	logic                    fend_q;
	logic                    far_q;

	logic [CNT_W-1:0]        dec_eff;
	logic signed [SUM_W-1:0] sum_nx;
	logic [SUM_W-1:0]        sum_mag;
	logic                    div_start;
	logic [DIV_W-1:0]        div_dvd;
	logic [DVS_W-1:0]        div_dvs;
	logic                    div_done;
	logic [DIV_W-1:0]        quo;
	logic [15:0]             rdata;
	logic [15:0]             s_mag;

	always_comb begin
		if (dec_cfg_q == 4'd0) dec_eff = CNT_W'(1);
		else if ({1'b0, dec_cfg_q} > 5'(DEC_MAX)) dec_eff = CNT_W'(DEC_MAX);
		else dec_eff = CNT_W'(dec_cfg_q);
	end

	assign sum_nx  = sum_q + SUM_W'(x_q);
	assign sum_mag = sum_nx < 0 ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
	assign s_mag   = s_q < 0 ? 16'(-s_q) : 16'(s_q);

	assign sts.grp_close = ({1'b0, cnt_q} + (CNT_W + 1)'(1)) >= {1'b0, dec_eff};
	assign sts.gate_on   = gate_thr_q != '0;
	assign sts.agc_on    = agc_target_q != '0;
	assign sts.duck_on   = duck_depth_q != '0;
	assign sts.fend      = fend_q;
	assign sts.fill_zero = fill_q == '0;
	assign sts.div_done  = div_done;
	assign sts.idx_last  = (idx_q + FILL_W'(1)) == fill_q;
	assign sts.out_free  = !out_valid || out_ready;

	// shared divider: group average and agc desired gain
	assign div_start = (cmd.acc && sts.grp_close) || cmd.adiv;
	assign div_dvd   = cmd.adiv ? DIV_W'({agc_target_q, 32'b0}) : DIV_W'(sum_mag);
	assign div_dvs   = cmd.adiv ? (aenv_q < 32'(UNITY) ? 32'(UNITY) : aenv_q)
	                            : DVS_W'(dec_eff);

	amd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quo)
	);

	amd_ram #(.WIDTH(16), .DEPTH(FRAME_SAMPLES)) u_store (
		.clk   (clk),
		.we    (cmd.store && (fill_q < FILL_W'(FRAME_SAMPLES))),
		.waddr (fill_q[AW-1:0]),
		.wdata (s_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// arithmetic for each step
	logic signed [SUM_W-1:0] avg;
	logic signed [GP_W-1:0]  gp;
	logic [31:0]             ga16;
	logic [47:0]             grel;
	logic                    gopen;
	logic signed [18:0]      glvl_nx;
	logic signed [33:0]      gmp;
	logic [31:0]             apk;
	logic                    agt;
	logic [47:0]             aprod;
	logic [19:0]             des;
	logic signed [20:0]      delta;
	logic [6:0]              dcl;
	logic [22:0]             xf;
	logic [48:0]             fprod;
	logic signed [36:0]      amp;
	logic signed [18:0]      dn;
	logic signed [33:0]      dmp;

	always_comb begin
		avg   = neg_q ? SUM_W'(-signed'(quo[SUM_W-1:0])) : signed'(quo[SUM_W-1:0]);
		gp    = GP_W'(avg) * GP_W'(signed'({1'b0, mic_gain_q}));
		ga16  = {s_mag, 16'b0};
		grel  = 48'(genv_q) * 48'(GATE_REL);
		gopen = genv_q > {1'b0, gate_thr_q, 16'b0};
		if (gopen && glvl_q < UNITY) begin
			glvl_nx = 19'(glvl_q) + 19'(GATE_UP);
			if (glvl_nx > 19'(UNITY)) glvl_nx = 19'(UNITY);
		end else begin
			glvl_nx = 19'(glvl_q) - 19'(GATE_DN);
			if (glvl_nx < 0) glvl_nx = '0;
		end
		gmp   = 34'(s_q) * signed'(34'(glvl_q));
		apk   = {peak_q, 16'b0};
		agt   = apk > aenv_q;
		aprod = 48'(agt ? apk - aenv_q : aenv_q) * 48'(agt ? AGC_ATK : AGC_REL);
		if (quo > 48'(AGC_MAX)) des = AGC_MAX;
		else if (quo < 48'(UNITY)) des = 20'(UNITY);
		else des = quo[19:0];
		delta = signed'({1'b0, des}) - signed'({1'b0, alvl_q});
		dcl   = duck_depth_q > DUCK_FULL ? DUCK_FULL : duck_depth_q;
		xf    = {DUCK_FULL - dcl, 16'b0};
		fprod = 49'(xf) * 49'(PCT_RECIP);
		amp   = 37'(s_q) * signed'(37'(alvl_q));
		dn    = signed'(19'(duck_q)) + (far_q ? -signed'(19'(DUCK_DN)) : signed'(19'(DUCK_UP)));
		if (dn < signed'(19'(floor_q))) dn = signed'(19'(floor_q));
		if (dn > signed'(19'(UNITY))) dn = signed'(19'(UNITY));
		dmp   = 34'(s_q) * signed'(34'(duck_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_cfg_q    <= 4'd3;
			mic_gain_q   <= 12'd256;
			gate_thr_q   <= '0;
			agc_target_q <= '0;
			duck_depth_q <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			genv_q       <= '0;
			glvl_q       <= '0;
			fill_q       <= '0;
			peak_q       <= '0;
			aenv_q       <= '0;
			alvl_q       <= 20'(UNITY);
			duck_q       <= UNITY;
			idx_q        <= '0;
			fend_q       <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_DECIMATION: dec_cfg_q    <= cfg_wdata[3:0];
					CFG_MIC_GAIN:   mic_gain_q   <= cfg_wdata[11:0];
					CFG_GATE_THR:   gate_thr_q   <= cfg_wdata[14:0];
					CFG_AGC_TARGET: agc_target_q <= cfg_wdata[14:0];
					CFG_DUCK_DEPTH: duck_depth_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (cmd.capture) fend_q <= in_fend;
			if (cmd.acc) begin
				if (sts.grp_close) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.grp_clr) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.genv) genv_q <= ga16 > genv_q ? ga16 : grel[47:16];
			if (cmd.glvl) glvl_q <= glvl_nx[16:0];
			if (cmd.store && (fill_q < FILL_W'(FRAME_SAMPLES))) begin
				fill_q <= fill_q + FILL_W'(1);
				if (s_mag > peak_q) peak_q <= s_mag;
			end
			if (cmd.aenv) aenv_q <= agt ? aenv_q + aprod[47:16] : aprod[47:16];
			if (cmd.alvl2) alvl_q <= alvl_q + 20'(tz_shr(48'(dprod_q), 16));
			if (cmd.dflr) idx_q <= '0;
			if (cmd.idx_inc) idx_q <= idx_q + FILL_W'(1);
			if (cmd.duck) duck_q <= dn[16:0];
			if (cmd.frame_clr) begin
				fill_q <= '0;
				peak_q <= '0;
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q   <= in_sample;
			far_q <= in_far;
		end
		if (cmd.acc && sts.grp_close) neg_q <= sum_nx < 0;
		if (cmd.gain) s_q <= sat16(tz_shr(48'(gp), 8));
		if (cmd.gmul) s_q <= 16'(tz_shr(48'(gmp), 16));
		if (cmd.alvl) dprod_q <= 36'(delta) * 36'(signed'({1'b0, AGC_SMOOTH}));
		if (cmd.dflr) floor_q <= fprod[48:32];
		if (cmd.rdw) s_q <= signed'(rdata);
		if (cmd.amul) s_q <= sat16(tz_shr(48'(amp), 16));
		if (cmd.dmul) s_q <= 16'(tz_shr(48'(dmp), 16));
		if (cmd.out_load) begin
			out_sample <= s_q;
			out_last   <= sts.idx_last;
		end
	end
endmodule

// File: rtl/mic_decimate_gate_agc_duck.sv
// ----------------------------------------------------------------------------
// mic_decimate_gate_agc_duck
// Boxcar decimator, noise gate, frame agc and far-end ducking for a mic path.
// ----------------------------------------------------------------------------
// a codec sample that does not close a group is only accumulated; one that
// closes a group waits on the 48-step shared divider, plus the gate steps when
// the gate is on; at the frame mark the agc update, when enabled, uses the
// divider again and the duck floor is set, then each buffered sample is played
// out through the ram read and multiply steps, waiting while the output stalls
// reset is asynchronous; the frame store needs no clearing pass after reset
module mic_decimate_gate_agc_duck #(
	parameter int FRAME_SAMPLES  = 64,
	parameter int MAX_DECIMATION = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [amd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // codec_sample
	input  logic                           s_axis_tlast,  // frame_end
	input  logic                           s_axis_tuser,  // far end busy flag
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,  // mic_sample
	output logic                           m_axis_tlast   // last_in_frame
);
	import amd_pkg::*;

	amd_cmd_t cmd;
	amd_sts_t sts;

	assign cfg_ready = 1'b1;

	amd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	amd_dp #(
		.FRAME_SAMPLES  (FRAME_SAMPLES),
		.MAX_DECIMATION (MAX_DECIMATION)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.in_sample  (signed'(s_axis_tdata)),
		.in_fend    (s_axis_tlast),
		.in_far     (s_axis_tuser),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);
endmodule

// File: tb/mic_front_checker.sv
// ----------------------------------------------------------------------------
// mic_front_checker
// Watches the config, input and output channels of the mic front end,
// predicts every output beat and compares it with what the block sends.
// ----------------------------------------------------------------------------
module mic_front_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [amd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,
	input  logic                           s_axis_tlast,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [15:0]                    m_axis_tdata,
	input  logic                           m_axis_tlast,
	output int                             fail_count,
	output int                             pending,
	output int                             beats_seen,
	output int                             frames_seen
);
	import amd_pkg::*;

	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} mic_beat_t;

	mic_beat_t expected_beats[$];

	logic [3:0]  decim_r;
	logic [11:0] gain_r;
	logic [14:0] thr_r;
	logic [14:0] target_r;
	logic [6:0]  depth_r;

	longint grp_sum, grp_cnt, genv, glvl, fill, peak, aenv, alvl, dlvl;
	longint store[64];

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// c-style division truncating toward zero
	function automatic longint qdiv(longint n, longint d);
		longint q;
		q = (n < 0 ? -n : n) / d;
		return n < 0 ? -q : q;
	endfunction

	task automatic front_reset();
		decim_r = 3; gain_r = 256; thr_r = 0; target_r = 0; depth_r = 0;
		grp_sum = 0; grp_cnt = 0; genv = 0; glvl = 0; fill = 0; peak = 0;
		aenv = 0; alvl = 65536; dlvl = 65536;
	endtask

	function automatic longint gate_sample(longint s);
		longint a;
		a = s < 0 ? -s : s;
		if ((a << 16) > genv) genv = a << 16;
		else genv = (genv * 65479) >> 16;
		if (genv > (longint'(thr_r) << 16) && glvl < 65536) begin
			glvl += 819;
			if (glvl > 65536) glvl = 65536;
		end else begin
			glvl -= 27;
			if (glvl < 0) glvl = 0;
		end
		return qdiv(s * glvl, 65536);
	endfunction

	task automatic predict_input(longint x, bit fend, bit far);
		longint dec, s, a, p, e, want, depth, flr;
		dec = decim_r;
		if (dec < 1) dec = 1;
		if (dec > 8) dec = 8;
		grp_sum += x;
		grp_cnt++;
		if (grp_cnt >= dec) begin
			s = clip16(qdiv(qdiv(grp_sum, dec) * gain_r, 256));
			grp_sum = 0; grp_cnt = 0;
			if (thr_r > 0) s = gate_sample(s);
			if (fill < 64) begin
				a = s < 0 ? -s : s;
				store[fill] = s;
				fill++;
				if (a > peak) peak = a;
			end
		end
		if (!fend) return;
		grp_sum = 0; grp_cnt = 0;
		if (fill == 0) return;
		if (target_r > 0) begin
			p = peak << 16;
			if (p > aenv) aenv += ((p - aenv) * 39322) >> 16;
			else aenv = (aenv * 62259) >> 16;
			e = aenv < 65536 ? 65536 : aenv;
			want = (longint'(target_r) << 32) / e;
			if (want > 786432) want = 786432;
			if (want < 65536) want = 65536;
			alvl += qdiv((want - alvl) * 13107, 65536);
		end
		depth = depth_r > 100 ? 100 : depth_r;
		flr = ((100 - depth) * 65536) / 100;
		for (int i = 0; i < fill; i++) begin
			s = store[i];
			if (target_r > 0) s = clip16(qdiv(s * alvl, 65536));
			if (depth > 0) begin
				dlvl += far ? -1311 : 197;
				if (dlvl < flr) dlvl = flr;
				if (dlvl > 65536) dlvl = 65536;
				s = qdiv(s * dlvl, 65536);
			end
			expected_beats.push_back({s[15:0], i == fill - 1});
		end
		fill = 0; peak = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mic_beat_t want_b;
		int errs;
		if (!arst_n) begin
			front_reset();
			expected_beats.delete();
			fail_count <= 0;
			pending <= 0;
			beats_seen <= 0;
			frames_seen <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DECIMATION: decim_r = cfg_data[3:0];
					CFG_MIC_GAIN:   gain_r = cfg_data[11:0];
					CFG_GATE_THR:   thr_r = cfg_data[14:0];
					CFG_AGC_TARGET: target_r = cfg_data[14:0];
					CFG_DUCK_DEPTH: depth_r = cfg_data[6:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_input(longint'($signed(s_axis_tdata)), s_axis_tlast, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				beats_seen <= beats_seen + 1;
				if (m_axis_tlast) frames_seen <= frames_seen + 1;
				if (expected_beats.size() == 0) begin
					$error("unexpected beat: mic_sample %0d", $signed(m_axis_tdata));
					errs++;
				end else begin
					want_b = expected_beats.pop_front();
					if (want_b.sample !== m_axis_tdata) begin
						$error("mic_sample expected %0d actual %0d", $signed(want_b.sample),
							$signed(m_axis_tdata));
						errs++;
					end
					if (want_b.last !== m_axis_tlast) begin
						$error("last_in_frame expected %0d actual %0d", want_b.last,
							m_axis_tlast);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			pending <= expected_beats.size();
		end
	end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives codec samples, frame marks and register settings into the mic front
// end with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import amd_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [15:0]           m_axis_tdata;
	logic                  m_axis_tlast;
	int                    fail_count, pending, beats_seen, frames_seen;
	int                    samples_sent;

	mic_decimate_gate_agc_duck uut (.*);

	mic_front_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	// output side stalls for a random gap before each beat
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk) m_axis_tready <= 0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 0;
	endtask

	task automatic send_sample(logic [15:0] d, bit fend, bit far, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		repeat (gap) @(negedge clk);
		if (gap > 0 || !s_axis_tvalid) @(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= fend;
		s_axis_tuser  <= far;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	// wait for all predicted beats, then let in-flight work drain
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic settings(int dec, int gain, int thr, int tgt, int dep);
		drain();
		write_reg(CFG_DECIMATION, dec);
		write_reg(CFG_MIC_GAIN, gain);
		write_reg(CFG_GATE_THR, thr);
		write_reg(CFG_AGC_TARGET, tgt);
		write_reg(CFG_DUCK_DEPTH, dep);
	endtask

	task automatic random_frame(int len, bit loud);
		logic [15:0] d;
		bit far;
		far = 1'($urandom_range(0, 1));
		for (int i = 0; i < len; i++) begin
			d = loud ? 16'($urandom()) : 16'($signed($urandom_range(0, 600)) - 300);
			send_sample(d, i == len - 1, $urandom_range(0, 3) == 0 ? ~far : far,
				$urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0; s_axis_tuser = 0;
		samples_sent = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: reset settings, extremes, partial group, empty frame
		send_sample(16'h7fff, 0, 0, 0);
		send_sample(16'h7fff, 0, 0, 0);
		send_sample(16'h7fff, 0, 0, 0);
		send_sample(16'h8000, 0, 1, 0);
		send_sample(16'h8000, 1, 1, 0);
		send_sample(16'h0001, 1, 0, 0);
		settings(1, 4095, 1, 32767, 100);
		send_sample(16'h8000, 0, 1, 0);
		send_sample(16'h7fff, 0, 0, 0);
		send_sample(16'hffff, 1, 1, 0);
		settings(0, 0, 32767, 1, 127);
		send_sample(16'h1234, 0, 0, 0);
		send_sample(16'hedcb, 1, 0, 0);
		settings(15, 256, 0, 0, 0);
		for (int i = 0; i < 9; i++) send_sample(16'h4000, i == 8, 0, 0);
		// decimation lowered mid-group
		settings(8, 300, 0, 0, 50);
		send_sample(16'h0100, 0, 0, 0);
		send_sample(16'h0100, 0, 0, 0);
		send_sample(16'h0100, 0, 0, 0);
		drain();
		write_reg(CFG_DECIMATION, 2);
		send_sample(16'h0100, 1, 1, 0);

		// overflowing frame store, then random phases
		settings(1, 256, 0, 8000, 30);
		random_frame(70, 1);
		while (samples_sent < 280) begin
			settings($urandom_range(0, 15), $urandom_range(0, 4095),
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32767),
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32767),
				$urandom_range(0, 127));
			repeat ($urandom_range(1, 3))
				random_frame($urandom_range(1, 24), $urandom_range(0, 2) != 0);
		end

		drain();
		$display("run: %0d codec samples in, %0d mic beats in %0d frames checked",
			samples_sent, beats_seen, frames_seen);
		$display("register settings varied across decimation, gain, gate, agc and duck");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/amd_pkg.sv
rtl/amd_ram.sv
rtl/amd_div.sv
rtl/amd_ctrl.sv
rtl/amd_dp.sv
rtl/mic_decimate_gate_agc_duck.sv
tb/mic_front_checker.sv
tb/testbench.sv
